// ----- rtl/html_char_classifier_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the HTML character classifier
// Shared property forms for immediate-implication and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef HTML_CHAR_CLASSIFIER_CORE_MACROS_SVH
`define HTML_CHAR_CLASSIFIER_CORE_MACROS_SVH

// check cons in the same cycle as ante
`define HCC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define HCC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/hcc_pkg.sv -----
// ----------------------------------------------------------------------------
// HTML character classifier package
// Payload types, character codes, class codes, scan modes and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package hcc_pkg;

   localparam int DEF_MAX_ENTITY_NAME = 32;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        end_of_line;
   } req_type;

   typedef struct packed {
      logic [15:0] out_unit;
      logic [2:0]  char_class;
      logic        line_last;
      logic        run_last;
   } rsp_type;

   localparam logic [2:0] CLS_PLAIN   = 3'd0;
   localparam logic [2:0] CLS_ENTITY  = 3'd1;
   localparam logic [2:0] CLS_TAG     = 3'd2;
   localparam logic [2:0] CLS_COMMENT = 3'd3;
   localparam logic [2:0] CLS_ATTR    = 3'd4;

   localparam logic [15:0] CH_LT    = 16'h003C;
   localparam logic [15:0] CH_GT    = 16'h003E;
   localparam logic [15:0] CH_BANG  = 16'h0021;
   localparam logic [15:0] CH_DASH  = 16'h002D;
   localparam logic [15:0] CH_AMP   = 16'h0026;
   localparam logic [15:0] CH_SEMI  = 16'h003B;
   localparam logic [15:0] CH_QUOTE = 16'h0022;

   typedef enum logic [3:0] {
      MODE_NORMAL  = 4'b0001,
      MODE_COMMENT = 4'b0010,
      MODE_TAG     = 4'b0100,
      MODE_ATTR    = 4'b1000
   } mode_type;

   typedef enum logic [2:0] {
      SRC_PRE_HEAD  = 3'd0,
      SRC_PRE_BODY  = 3'd1,
      SRC_CUR       = 3'd2,
      SRC_POST_HEAD = 3'd3,
      SRC_POST_BODY = 3'd4
   } src_type;

   typedef struct packed {
      logic    load;
      logic    emit;
      logic    last;
      logic    idx_clr;
      logic    idx_inc;
      src_type src;
   } hcc_cmd_type;

   typedef struct packed {
      logic pre_on;
      logic pre_body;
      logic pre_idx_last;
      logic cur_on;
      logic post_on;
      logic post_body;
      logic post_idx_last;
      logic out_free;
   } hcc_status_type;

   function automatic logic is_alnum(input logic [15:0] c);
      is_alnum = ((c >= 16'h0030) && (c <= 16'h0039)) ||
                 ((c >= 16'h0041) && (c <= 16'h005A)) ||
                 ((c >= 16'h0061) && (c <= 16'h007A));
   endfunction

endpackage

// ----- rtl/hcc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hcc_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/hcc_controller.sv -----
// ----------------------------------------------------------------------------
// HTML character classifier controller
// Sequences the result transactions of one input transaction: leading
// release, the unit itself, then the release at line end.
// ----------------------------------------------------------------------------
module hcc_controller import hcc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  hcc_status_type stat,
   output hcc_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_PRE_HEAD  = 6'b000010,
      ST_PRE_BODY  = 6'b000100,
      ST_CUR       = 6'b001000,
      ST_POST_HEAD = 6'b010000,
      ST_POST_BODY = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;
   state_type after_pre;
   state_type after_cur;
   state_type nxt;

   always_comb begin
      after_cur = stat.post_on ? ST_POST_HEAD : ST_IDLE;
      after_pre = stat.cur_on ? ST_CUR : after_cur;
   end

   always_comb begin
      state_in    = state_ff;
      nxt         = ST_IDLE;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.src     = SRC_CUR;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = stat.pre_on ? ST_PRE_HEAD : after_pre;
            end
         end
         ST_PRE_HEAD: begin
            cmd.src     = SRC_PRE_HEAD;
            cmd.idx_clr = 1'b1;
            nxt         = stat.pre_body ? ST_PRE_BODY : after_pre;
         end
         ST_PRE_BODY: begin
            cmd.src = SRC_PRE_BODY;
            nxt     = stat.pre_idx_last ? after_pre : ST_PRE_BODY;
         end
         ST_CUR: begin
            cmd.src = SRC_CUR;
            nxt     = after_cur;
         end
         ST_POST_HEAD: begin
            cmd.src     = SRC_POST_HEAD;
            cmd.idx_clr = 1'b1;
            nxt         = stat.post_body ? ST_POST_BODY : ST_IDLE;
         end
         ST_POST_BODY: begin
            cmd.src = SRC_POST_BODY;
            nxt     = stat.post_idx_last ? ST_IDLE : ST_POST_BODY;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if ((state_ff != ST_IDLE) && stat.out_free && (state_ff inside {ST_PRE_HEAD,
            ST_PRE_BODY, ST_CUR, ST_POST_HEAD, ST_POST_BODY})) begin
         cmd.emit    = 1'b1;
         cmd.last    = (nxt == ST_IDLE);
         cmd.idx_inc = (state_ff == ST_PRE_BODY) || (state_ff == ST_POST_BODY);
         state_in    = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/hcc_datapath.sv -----
// ----------------------------------------------------------------------------
// HTML character classifier datapath
// Scan state, held entity name store, release plan and result register.
// ----------------------------------------------------------------------------
module hcc_datapath import hcc_pkg::*; #(
   parameter int MAX_ENTITY_NAME = DEF_MAX_ENTITY_NAME
) (
   input  logic           clock,
   input  logic           reset,
   input  req_type        req_data,
   input  hcc_cmd_type    cmd,
   output hcc_status_type stat,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data
);

   localparam int CNT_W = $clog2(MAX_ENTITY_NAME + 1);
   localparam int IDX_W = (MAX_ENTITY_NAME > 1) ? $clog2(MAX_ENTITY_NAME) : 1;
   localparam int LEN_W = (CNT_W > 2) ? CNT_W : 2;

   typedef struct packed {
      logic             on;
      logic             is_ent;
      logic [2:0]       cls;
      logic [LEN_W-1:0] len;
   } flush_type;

   typedef struct packed {
      flush_type   pre;
      logic        cur_on;
      logic [2:0]  cur_cls;
      logic [15:0] unit;
      logic        eol;
      flush_type   post;
   } plan_type;

   mode_type         mode_ff, mode_in;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       open_ff, open_in;
   logic [1:0]       dash_ff, dash_in;
   plan_type         plan_ff, plan_new, plan_cur;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic        wr_en;
   logic [15:0] rd_data;
   logic [15:0] c;
   logic        eol;
   logic        do_normal;
   logic        do_tag;
   logic [15:0] emit_unit;
   logic [2:0]  emit_cls;

   assign c   = req_data.code_unit;
   assign eol = req_data.end_of_line;

   always_comb begin
      plan_new      = '0;
      plan_new.unit = c;
      plan_new.eol  = eol;
      mode_in       = mode_ff;
      pend_in       = pend_ff;
      cnt_in        = cnt_ff;
      open_in       = open_ff;
      dash_in       = dash_ff;
      wr_en         = 1'b0;
      do_normal     = 1'b0;
      do_tag        = 1'b0;
      case (mode_ff)
         MODE_COMMENT: begin
            plan_new.cur_on  = 1'b1;
            plan_new.cur_cls = CLS_COMMENT;
            if ((c == CH_GT) && (dash_ff >= 2'd2)) begin
               mode_in = MODE_NORMAL;
               dash_in = 2'd0;
            end else if (c == CH_DASH) begin
               if (dash_ff < 2'd2) begin
                  dash_in = dash_ff + 2'd1;
               end
            end else begin
               dash_in = 2'd0;
            end
         end
         MODE_TAG: begin
            do_tag = 1'b1;
         end
         MODE_ATTR: begin
            plan_new.cur_on = 1'b1;
            if (c == CH_QUOTE) begin
               plan_new.cur_cls = CLS_PLAIN;
               mode_in          = MODE_TAG;
            end else begin
               plan_new.cur_cls = CLS_ATTR;
            end
         end
         default: begin
            if (pend_ff) begin
               plan_new.pre.is_ent = 1'b1;
               plan_new.pre.len    = LEN_W'(cnt_ff);
               if (is_alnum(c)) begin
                  if (cnt_ff < CNT_W'(MAX_ENTITY_NAME)) begin
                     wr_en  = 1'b1;
                     cnt_in = cnt_ff + CNT_W'(1);
                  end else begin
                     plan_new.pre.on  = 1'b1;
                     plan_new.pre.cls = CLS_PLAIN;
                     plan_new.cur_on  = 1'b1;
                     plan_new.cur_cls = CLS_PLAIN;
                     pend_in          = 1'b0;
                     cnt_in           = '0;
                  end
               end else if ((c == CH_SEMI) && (cnt_ff != '0)) begin
                  plan_new.pre.on  = 1'b1;
                  plan_new.pre.cls = CLS_ENTITY;
                  plan_new.cur_on  = 1'b1;
                  plan_new.cur_cls = CLS_ENTITY;
                  pend_in          = 1'b0;
                  cnt_in           = '0;
               end else begin
                  plan_new.pre.on  = 1'b1;
                  plan_new.pre.cls = CLS_PLAIN;
                  pend_in          = 1'b0;
                  cnt_in           = '0;
                  do_normal        = 1'b1;
               end
            end else if (open_ff != 2'd0) begin
               if (c == ((open_ff == 2'd1) ? CH_BANG : CH_DASH)) begin
                  if (open_ff == 2'd3) begin
                     plan_new.pre.on  = 1'b1;
                     plan_new.pre.cls = CLS_COMMENT;
                     plan_new.pre.len = LEN_W'(2);
                     plan_new.cur_on  = 1'b1;
                     plan_new.cur_cls = CLS_COMMENT;
                     open_in          = 2'd0;
                     mode_in          = MODE_COMMENT;
                     dash_in          = 2'd2;
                  end else begin
                     open_in = open_ff + 2'd1;
                  end
               end else begin
                  plan_new.pre.on  = 1'b1;
                  plan_new.pre.cls = CLS_TAG;
                  plan_new.pre.len = LEN_W'(open_ff - 2'd1);
                  open_in          = 2'd0;
                  mode_in          = MODE_TAG;
                  do_tag           = 1'b1;
               end
            end else begin
               do_normal = 1'b1;
            end
         end
      endcase
      if (do_normal) begin
         if (c == CH_LT) begin
            open_in = 2'd1;
         end else if (c == CH_AMP) begin
            pend_in = 1'b1;
            cnt_in  = '0;
         end else begin
            plan_new.cur_on  = 1'b1;
            plan_new.cur_cls = CLS_PLAIN;
         end
      end
      if (do_tag) begin
         plan_new.cur_on = 1'b1;
         if (c == CH_QUOTE) begin
            plan_new.cur_cls = CLS_ATTR;
            mode_in          = MODE_ATTR;
         end else begin
            plan_new.cur_cls = CLS_TAG;
            if (c == CH_GT) begin
               mode_in = MODE_NORMAL;
            end
         end
      end
      if (eol) begin
         if (pend_in) begin
            plan_new.post.on     = 1'b1;
            plan_new.post.is_ent = 1'b1;
            plan_new.post.cls    = CLS_PLAIN;
            plan_new.post.len    = LEN_W'(cnt_in);
            pend_in              = 1'b0;
            cnt_in               = '0;
         end
         if (open_in != 2'd0) begin
            plan_new.post.on  = 1'b1;
            plan_new.post.cls = CLS_TAG;
            plan_new.post.len = LEN_W'(open_in - 2'd1);
            open_in           = 2'd0;
            mode_in           = MODE_TAG;
         end
         dash_in = 2'd0;
      end
   end

   hcc_ram #(
      .WIDTH (16),
      .DEPTH (MAX_ENTITY_NAME),
      .ADDR_W(IDX_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.load & wr_en),
      .wr_addr(cnt_ff[IDX_W-1:0]),
      .wr_data(c),
      .rd_addr(idx_in),
      .rd_data(rd_data)
   );

   always_comb begin
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_comb begin
      plan_cur           = cmd.load ? plan_new : plan_ff;
      stat.pre_on        = plan_cur.pre.on;
      stat.pre_body      = (plan_cur.pre.len != '0);
      stat.pre_idx_last  = ((LEN_W'(idx_ff) + LEN_W'(1)) == plan_cur.pre.len);
      stat.cur_on        = plan_cur.cur_on;
      stat.post_on       = plan_cur.post.on;
      stat.post_body     = (plan_cur.post.len != '0);
      stat.post_idx_last = ((LEN_W'(idx_ff) + LEN_W'(1)) == plan_cur.post.len);
      stat.out_free      = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      emit_unit = plan_ff.unit;
      emit_cls  = plan_ff.cur_cls;
      case (cmd.src)
         SRC_PRE_HEAD: begin
            emit_unit = plan_ff.pre.is_ent ? CH_AMP : CH_LT;
            emit_cls  = plan_ff.pre.cls;
         end
         SRC_PRE_BODY: begin
            emit_unit = plan_ff.pre.is_ent ? rd_data :
                        ((idx_ff == '0) ? CH_BANG : CH_DASH);
            emit_cls  = plan_ff.pre.cls;
         end
         SRC_POST_HEAD: begin
            emit_unit = plan_ff.post.is_ent ? CH_AMP : CH_LT;
            emit_cls  = plan_ff.post.cls;
         end
         SRC_POST_BODY: begin
            emit_unit = plan_ff.post.is_ent ? rd_data :
                        ((idx_ff == '0) ? CH_BANG : CH_DASH);
            emit_cls  = plan_ff.post.cls;
         end
         default: begin
            emit_unit = plan_ff.unit;
            emit_cls  = plan_ff.cur_cls;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_in.out_unit   = emit_unit;
         rsp_in.char_class = emit_cls;
         rsp_in.line_last  = cmd.last & plan_ff.eol;
         rsp_in.run_last   = cmd.last;
         rsp_valid_in      = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         open_ff      <= 2'd0;
         dash_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            mode_ff <= mode_in;
            pend_ff <= pend_in;
            cnt_ff  <= cnt_in;
            open_ff <= open_in;
            dash_ff <= dash_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         plan_ff <= plan_new;
      end
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/html_char_classifier_core.sv -----
// ----------------------------------------------------------------------------
// HTML character classifier core: one result per cycle from a result register
// while the receiver is ready; an item gives none when its unit is held. The
// first result passes the controller state and result registers; an item gives
// up to 34. Reset clears scan state and handshakes, not the entity store.
// ----------------------------------------------------------------------------
`include "html_char_classifier_core_macros.svh"

module html_char_classifier_core import hcc_pkg::*; #(
   parameter int MAX_ENTITY_NAME = DEF_MAX_ENTITY_NAME
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   hcc_cmd_type    cmd;
   hcc_status_type stat;

   hcc_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   hcc_datapath #(
      .MAX_ENTITY_NAME(MAX_ENTITY_NAME)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   `HCC_ASSERT_IMP(a_emit_needs_room, clock, reset, cmd.emit, (!rsp_valid || rsp_ready), "result overwritten")
   `HCC_ASSERT_NXT(a_last_frees_input, clock, reset, cmd.emit && cmd.last, req_ready, "not idle after last result")
   `HCC_ASSERT_IMP(a_no_accept_mid_run, clock, reset, req_valid && req_ready, !cmd.emit, "accept during emission")
   `HCC_ASSERT_IMP(a_line_last_ends_run, clock, reset, rsp_valid && rsp_data.line_last, rsp_data.run_last, "line end not on run end")

endmodule
